### rtl/core/rkc_pkg.sv
// Package for the reference-counted key cache: payload structs, status codes,
// controller state and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package rkc_pkg;

    // Default sizing
    localparam int SETS_DEF     = 512;
    localparam int WAYS_DEF     = 4;
    localparam int REF_BITS_DEF = 16;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 11;
    localparam int COUNT_W  = 16;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_UNLOAD = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_FULL        = 3'd2,
        ST_DECREMENTED = 3'd3,
        ST_REMOVED     = 3'd4,
        ST_NOT_FOUND   = 3'd5
    } t_status;

    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] node_key;
    } t_rkc_in;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] ref_count;
    } t_rkc_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_LOOKUP
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;        // capture input transaction
        logic rd_from_in;  // RAM read address from input key
        logic div_step;    // one remainder stage
        logic clr_wr;      // clearing pass write
        logic commit;      // write back row and load result register
    } t_rkc_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_free;
    } t_rkc_sts;

endpackage

`default_nettype wire

### rtl/core/rkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/rkc_ctrl.sv
// Controller state machine for the key cache: clearing pass, set selection,
// read and write-back sequencing. Depends on rkc_pkg.
`default_nettype none

module rkc_ctrl #(
    parameter int SETS = rkc_pkg::SETS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rkc_pkg::t_rkc_sts i_sts,
    output rkc_pkg::t_rkc_cmd      o_cmd
);

    localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

    rkc_pkg::t_state r_state;
    rkc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rkc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            rkc_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = rkc_pkg::S_IDLE;
                end
            end
            rkc_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.rd_from_in = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // power-of-two sets: read issued now from the key's low bits
                    n_state = POW2 ? rkc_pkg::S_LOOKUP : rkc_pkg::S_DIVIDE;
                end
            end
            rkc_pkg::S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = rkc_pkg::S_READ;
                end
            end
            rkc_pkg::S_READ: begin
                n_state = rkc_pkg::S_LOOKUP;
            end
            rkc_pkg::S_LOOKUP: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = rkc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rkc_pkg::S_IDLE;
            end
        endcase
    end

    // An accepted transaction always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rkc_pkg::S_IDLE && i_in_valid) |=> (r_state != rkc_pkg::S_IDLE))
        else $error("accepted transaction did not leave idle");

    // A blocked result keeps the lookup pending
    a_lookup_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rkc_pkg::S_LOOKUP && !i_sts.out_free) |=> (r_state == rkc_pkg::S_LOOKUP))
        else $error("lookup left while result register busy");

    // Set read only follows the remainder sequence
    a_read_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rkc_pkg::S_READ) |-> ($past(r_state) == rkc_pkg::S_DIVIDE))
        else $error("read state entered without remainder");

endmodule

`default_nettype wire

### rtl/core/rkc_datapath.sv
// Datapath for the key cache: set remainder, set RAM, way compare,
// count update and result register. Depends on rkc_pkg and rkc_ram.
`default_nettype none

module rkc_datapath #(
    parameter int SETS     = rkc_pkg::SETS_DEF,
    parameter int WAYS     = rkc_pkg::WAYS_DEF,
    parameter int REF_BITS = rkc_pkg::REF_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rkc_pkg::t_rkc_cmd i_cmd,
    input  wire rkc_pkg::t_rkc_in  i_in_data,
    output rkc_pkg::t_rkc_sts      o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rkc_pkg::t_rkc_out      o_out_data
);

    localparam int KEY_W   = rkc_pkg::KEY_W;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W   = SET_W + WAY_W;
    localparam int ENTRY_W = 1 + KEY_W + REF_BITS;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int CNT_W   = 2;
    localparam bit POW2    = ((SETS & (SETS - 1)) == 0);

    localparam logic [SET_W-1:0]    SET_TOP  = SET_W'(SETS - 1);
    localparam logic [CNT_W-1:0]    DIV_QUOT = CNT_W'(0);
    localparam logic [CNT_W-1:0]    DIV_PROD = CNT_W'(1);
    localparam logic [CNT_W-1:0]    DIV_TOP  = CNT_W'(2);
    localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);
    // floor(2^32 / SETS): the estimated quotient is exact or one short
    localparam logic [KEY_W-1:0]    RECIP    = KEY_W'((64'd1 << KEY_W) / 64'(SETS));
    localparam logic [KEY_W-1:0]    SETS_K   = KEY_W'(SETS);

    logic [SET_W-1:0]    r_set;
    logic [KEY_W-1:0]    r_key;
    rkc_pkg::t_kind      r_kind;
    logic [KEY_W-1:0]    r_quot;
    logic [KEY_W-1:0]    r_qd;
    logic [CNT_W-1:0]    r_div_cnt;
    logic [SET_W-1:0]    r_clr_addr;
    logic                r_out_valid;
    rkc_pkg::t_rkc_out   r_out;

    logic [SET_W-1:0]    in_set;
    logic [2*KEY_W-1:0]  recip_prod;
    logic [KEY_W-1:0]    qd_prod;
    logic [KEY_W-1:0]    rem_est;
    logic [KEY_W-1:0]    rem_nx;
    logic [SET_W-1:0]    rd_addr;
    logic [SET_W-1:0]    wr_addr;
    logic [ROW_W-1:0]    wr_data;
    logic                wr_en;
    logic [ROW_W-1:0]    rd_data;

    logic                found;
    logic [WAY_W-1:0]    hit_way;
    logic                have_free;
    logic [WAY_W-1:0]    free_way;
    logic [ENTRY_W-1:0]  hit_e;
    logic [REF_BITS-1:0] hit_refs;

    logic [ROW_W-1:0]    new_row;
    rkc_pkg::t_status    res_status;
    logic                res_has_slot;
    logic [WAY_W-1:0]    res_way;
    logic [REF_BITS-1:0] res_cnt;
    logic [IDX_W-1:0]    slot_wide;
    logic [rkc_pkg::SLOT_W+IDX_W-1:0]     slot_ext;
    logic [rkc_pkg::COUNT_W+REF_BITS-1:0] cnt_ext;

    // Set of the incoming key when SETS is a power of two
    always_comb begin
        if (SETS == 1) begin
            in_set = '0;
        end else begin
            in_set = i_in_data.node_key[SET_W-1:0];
        end
    end

    // Remainder by reciprocal: quotient estimate, back-multiply, one correction
    assign recip_prod = r_key * RECIP;
    assign qd_prod    = r_quot * SETS_K;
    assign rem_est    = r_key - r_qd;
    assign rem_nx     = (rem_est >= SETS_K) ? (rem_est - SETS_K) : rem_est;

    // Transaction capture and remainder stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_in_data.node_key;
            r_kind <= i_in_data.kind;
            r_set  <= POW2 ? in_set : '0;
        end else if (i_cmd.div_step) begin
            case (r_div_cnt)
                DIV_QUOT: begin
                    r_quot <= recip_prod[2*KEY_W-1:KEY_W];
                end
                DIV_PROD: begin
                    r_qd <= qd_prod;
                end
                default: begin
                    r_set <= rem_nx[SET_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + SET_W'(1);
        end
    end

    // Set RAM: one row holds all ways of a set
    assign rd_addr = i_cmd.rd_from_in ? in_set : r_set;
    assign wr_en   = i_cmd.clr_wr | i_cmd.commit;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_set;
    assign wr_data = i_cmd.clr_wr ? '0 : new_row;

    rkc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Parallel way compare, lowest way wins
    always_comb begin
        logic [ENTRY_W-1:0] e;
        found     = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        free_way  = '0;
        e         = '0;
        for (int w = 0; w < WAYS; w++) begin
            e = rd_data[w*ENTRY_W +: ENTRY_W];
            if (e[ENTRY_W-1]) begin
                if (!found && (e[ENTRY_W-2 -: KEY_W] == r_key)) begin
                    found   = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_way  = WAY_W'(w);
            end
        end
    end

    assign hit_e    = rd_data[hit_way*ENTRY_W +: ENTRY_W];
    assign hit_refs = hit_e[REF_BITS-1:0];

    // Row update and result
    always_comb begin
        new_row      = rd_data;
        res_status   = rkc_pkg::ST_FULL;
        res_has_slot = 1'b0;
        res_way      = '0;
        res_cnt      = '0;
        case (r_kind)
            rkc_pkg::KIND_LOAD: begin
                if (found) begin
                    res_status   = rkc_pkg::ST_HIT;
                    res_has_slot = 1'b1;
                    res_way      = hit_way;
                    // saturate at the largest count
                    res_cnt      = (hit_refs == REF_MAX) ? hit_refs : hit_refs + REF_ONE;
                    new_row[hit_way*ENTRY_W +: ENTRY_W] = {1'b1, r_key, res_cnt};
                end else if (have_free) begin
                    res_status   = rkc_pkg::ST_INSERTED;
                    res_has_slot = 1'b1;
                    res_way      = free_way;
                    res_cnt      = REF_ONE;
                    new_row[free_way*ENTRY_W +: ENTRY_W] = {1'b1, r_key, REF_ONE};
                end else begin
                    res_status = rkc_pkg::ST_FULL;
                end
            end
            rkc_pkg::KIND_UNLOAD: begin
                if (!found) begin
                    res_status = rkc_pkg::ST_NOT_FOUND;
                end else if (hit_refs == REF_ONE) begin
                    res_status   = rkc_pkg::ST_REMOVED;
                    res_has_slot = 1'b1;
                    res_way      = hit_way;
                    new_row[hit_way*ENTRY_W + ENTRY_W - 1] = 1'b0;
                end else begin
                    res_status   = rkc_pkg::ST_DECREMENTED;
                    res_has_slot = 1'b1;
                    res_way      = hit_way;
                    res_cnt      = hit_refs - REF_ONE;
                    new_row[hit_way*ENTRY_W +: ENTRY_W] = {1'b1, r_key, res_cnt};
                end
            end
            default: begin
                res_status = rkc_pkg::ST_FULL;
            end
        endcase
    end

    // Slot number = set * WAYS + way, reported in the low output bits
    assign slot_wide = res_has_slot
                       ? (IDX_W'(r_set) * IDX_W'(WAYS) + IDX_W'(res_way)) : '0;
    assign slot_ext  = {{rkc_pkg::SLOT_W{1'b0}}, slot_wide};
    assign cnt_ext   = {{rkc_pkg::COUNT_W{1'b0}}, res_cnt};

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.status     <= res_status;
            r_out.slot_index <= slot_ext[rkc_pkg::SLOT_W-1:0];
            r_out.ref_count  <= cnt_ext[rkc_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.clr_last = (r_clr_addr == SET_TOP);
    assign o_sts.div_last = (r_div_cnt == DIV_TOP);

    // A committed lookup always presents a result next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed lookup produced no result");

    // Fresh insert reports a count of one
    a_insert_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == rkc_pkg::ST_INSERTED) |-> (r_out.ref_count == 16'd1))
        else $error("insert with count other than one");

    // No-slot outcomes carry zero slot and count
    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == rkc_pkg::ST_FULL
                         || r_out.status == rkc_pkg::ST_NOT_FOUND))
        |-> (r_out.slot_index == '0 && r_out.ref_count == '0))
        else $error("full or not-found result with nonzero fields");

endmodule

`default_nettype wire

### rtl/core/refcounted_key_cache.sv
// Top level of the reference-counted key cache: controller plus datapath.
// Depends on rkc_pkg, rkc_ctrl, rkc_datapath (and rkc_ram below it).
//
//   Channel   Dir   Handshake                 Payload
//   in        in    i_in_valid / o_in_ready   i_in_data  (kind, node_key)
//   out       out   o_out_valid / i_out_ready o_out_data (status, slot_index, ref_count)
//
// With SETS a power of two an operation is a set RAM read, then way compare,
// count update and row write-back. Otherwise the set comes from a reciprocal
// multiply, back-multiply and correction, each registered, before the set RAM
// read, way compare and write-back. After reset a clearing pass writes every
// set row before the first input transaction is taken. A result waits in the
// output register; the write-back of the next operation stalls until it is free.
`default_nettype none

module refcounted_key_cache #(
    parameter int SETS     = rkc_pkg::SETS_DEF,
    parameter int WAYS     = rkc_pkg::WAYS_DEF,
    parameter int REF_BITS = rkc_pkg::REF_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire rkc_pkg::t_rkc_in i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output rkc_pkg::t_rkc_out     o_out_data
);

    rkc_pkg::t_rkc_cmd cmd;
    rkc_pkg::t_rkc_sts sts;

    rkc_ctrl #(
        .SETS (SETS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rkc_datapath #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .REF_BITS (REF_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
